[sv/vpt_pkg.sv]
// Shared constants and types for the vector parallel test block.
`default_nettype none

package vpt_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int LIMB_W          = 32;
  localparam int TOL_W           = 17;
  localparam int TOL_FRAC        = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 17'd65526;

  typedef enum logic [1:0] {
    REL_NONE     = 2'd0,
    REL_SAME     = 2'd1,
    REL_OPPOSITE = 2'd2
  } relation_t;

  typedef struct packed {
    logic       zero_len;
    logic [2:0] mixed_sign;
  } prod_tag_t;

  typedef struct packed {
    logic zero_len;
    logic dot_neg;
  } cmp_tag_t;

endpackage

`default_nettype wire

[sv/vpt_if.sv]
// Channel interfaces: vector pair input, relation output, tolerance write.
`default_nettype none

interface vpt_in_if
  import vpt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] first_z;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] second_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

interface vpt_out_if
  import vpt_pkg::*;
;
  logic      valid;
  logic      ready;
  relation_t relation;

  modport source (output valid, relation, input ready);
  modport sink (input valid, relation, output ready);
endinterface

interface vpt_cfg_if
  import vpt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[sv/vector_parallel_test_core.sv]
// Vector parallel test: cosine tolerance check of two 3-D fixed-point vectors.
//
// in_ch carries one vector pair per word (six signed coordinates); out_ch returns
// one relation word per pair, in order: none, same direction or opposite direction.
// cfg_ch writes the Q1.16 cosine tolerance; it is always ready. The user must
// write it only while no pair is in flight; the block does not enforce this.
// Throughput is one pair per cycle while in_ch is ready. From input acceptance
// a pair passes the sign and magnitude register, the coordinate product
// multipliers (depth L1), stages 3 and 4, the dot and length square multipliers
// (depth L2) and the tolerance multiplier (depth L3); each is limb count plus one.
// Results enter an output FIFO of L1 + L2 + L3 + 5 words. A credit counter
// covers pipeline plus FIFO, so in_ch stays ready while the receiver stalls
// until that many words are outstanding, then drops ready; nothing is lost.
// Synchronous reset empties the pipeline and FIFO and loads the tolerance
// with 65526.
`default_nettype none

module vector_parallel_test_core
  import vpt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vpt_in_if.sink    in_ch,
  vpt_out_if.source out_ch,
  vpt_cfg_if.sink   cfg_ch
);

  localparam int W         = COORD_WIDTH;
  localparam int PW        = 2 * W;
  localparam int SW        = PW + 2;
  localparam int SW1       = SW + 1;
  localparam int TSW       = 2 * TOL_W;
  localparam int QW        = 2 * SW;
  localparam int RW        = QW + TSW;
  localparam int LHS_SHIFT = 2 * TOL_FRAC;
  localparam int L_M1      = (W + LIMB_W - 1) / LIMB_W + 1;
  localparam int L_M2      = (SW + LIMB_W - 1) / LIMB_W + 1;
  localparam int L_M3      = (TSW + LIMB_W - 1) / LIMB_W + 1;
  localparam int DEPTH     = L_M1 + L_M2 + L_M3 + 5;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CT_W      = $bits(cmp_tag_t);
  localparam int D3_W      = CT_W + QW;

  logic             in_accept;
  logic             out_accept;
  logic [TOL_W-1:0] tol_r;
  logic [TSW-1:0]   tol_sq_r;

  logic [W-1:0] a_raw [3];
  logic [W-1:0] b_raw [3];
  logic [2:0]   sa_c;
  logic [2:0]   sb_c;
  logic [W-1:0] mag_a_nxt [3];
  logic [W-1:0] mag_b_nxt [3];
  prod_tag_t    s1_tag_nxt;

  logic         s1_vld_r;
  logic [W-1:0] mag_a_r [3];
  logic [W-1:0] mag_b_r [3];
  prod_tag_t    s1_tag_r;

  logic [PW-1:0] ab [3];
  logic [PW-1:0] aa [3];
  logic [PW-1:0] bb [3];
  logic          m1_vld;
  prod_tag_t     m1_tag;

  logic [SW-1:0] pos_nxt, neg_nxt, la_nxt, lb_nxt;
  logic          s3_vld_r;
  logic          s3_zero_r;
  logic [SW-1:0] pos_r, neg_r, la_r, lb_r;

  logic [SW1-1:0] diff_pn;
  cmp_tag_t       s4_tag_nxt;
  logic [SW-1:0]  dot_mag_nxt;
  logic           s4_vld_r;
  cmp_tag_t       s4_tag_r;
  logic [SW-1:0]  dot_mag_r, la4_r, lb4_r;

  logic [QW-1:0] q_sq;
  logic [QW-1:0] p_len;
  logic          m2_vld;
  cmp_tag_t      m2_tag;

  logic [RW-1:0]   rhs;
  logic            m3_vld;
  logic [D3_W-1:0] m3_data;
  cmp_tag_t        m3_tag;
  logic [QW-1:0]   m3_q;
  logic [RW-1:0]   lhs;
  relation_t       rel_c;

  relation_t          fifo_mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   fcnt_r, fcnt_nxt, cnt_r, cnt_nxt;
  logic               wr_en;

  // handshakes
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (cnt_r != CNT_W'(DEPTH));
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (fcnt_r != '0);
  assign out_ch.relation = fifo_mem[rd_ptr_r];
  assign out_accept   = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_ch.valid) begin
      tol_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    tol_sq_r <= TSW'(tol_r) * TSW'(tol_r);
  end

  // stage 1: sign and magnitude
  assign a_raw[0] = in_ch.first_x;
  assign a_raw[1] = in_ch.first_y;
  assign a_raw[2] = in_ch.first_z;
  assign b_raw[0] = in_ch.second_x;
  assign b_raw[1] = in_ch.second_y;
  assign b_raw[2] = in_ch.second_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sa_c[k]      = a_raw[k][W-1];
      sb_c[k]      = b_raw[k][W-1];
      mag_a_nxt[k] = sa_c[k] ? (~a_raw[k] + 1'b1) : a_raw[k];
      mag_b_nxt[k] = sb_c[k] ? (~b_raw[k] + 1'b1) : b_raw[k];
    end
    s1_tag_nxt.mixed_sign = sa_c ^ sb_c;
    s1_tag_nxt.zero_len   = (a_raw[0] == '0 && a_raw[1] == '0 && a_raw[2] == '0) ||
                            (b_raw[0] == '0 && b_raw[1] == '0 && b_raw[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    mag_a_r  <= mag_a_nxt;
    mag_b_r  <= mag_b_nxt;
    s1_tag_r <= s1_tag_nxt;
  end

  // coordinate products
  for (genvar k = 0; k < 3; k++) begin : g_prod
    vpt_mul #(.A_W(W), .B_W(W)) u_ab (
      .clk (clk), .a (mag_a_r[k]), .b (mag_b_r[k]), .p (ab[k])
    );
    vpt_mul #(.A_W(W), .B_W(W)) u_aa (
      .clk (clk), .a (mag_a_r[k]), .b (mag_a_r[k]), .p (aa[k])
    );
    vpt_mul #(.A_W(W), .B_W(W)) u_bb (
      .clk (clk), .a (mag_b_r[k]), .b (mag_b_r[k]), .p (bb[k])
    );
  end

  vpt_dly #(.DATA_W($bits(prod_tag_t)), .DEPTH(L_M1)) u_dly1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s1_vld_r),
    .data_i (s1_tag_r),
    .vld_o  (m1_vld),
    .data_o (m1_tag)
  );

  // stage 3: split dot terms by sign, sum lengths
  always_comb begin
    pos_nxt = '0;
    neg_nxt = '0;
    la_nxt  = '0;
    lb_nxt  = '0;
    for (int k = 0; k < 3; k++) begin
      if (m1_tag.mixed_sign[k]) begin
        neg_nxt = neg_nxt + SW'(ab[k]);
      end else begin
        pos_nxt = pos_nxt + SW'(ab[k]);
      end
      la_nxt = la_nxt + SW'(aa[k]);
      lb_nxt = lb_nxt + SW'(bb[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_zero_r <= m1_tag.zero_len;
    pos_r     <= pos_nxt;
    neg_r     <= neg_nxt;
    la_r      <= la_nxt;
    lb_r      <= lb_nxt;
  end

  // stage 4: dot magnitude and sign
  assign diff_pn = SW1'(pos_r) - SW1'(neg_r);

  always_comb begin
    s4_tag_nxt.zero_len = s3_zero_r;
    s4_tag_nxt.dot_neg  = diff_pn[SW];
    dot_mag_nxt = diff_pn[SW] ? (neg_r - pos_r) : diff_pn[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_tag_r  <= s4_tag_nxt;
    dot_mag_r <= dot_mag_nxt;
    la4_r     <= la_r;
    lb4_r     <= lb_r;
  end

  // dot squared and length product
  vpt_mul #(.A_W(SW), .B_W(SW)) u_dot_sq (
    .clk (clk), .a (dot_mag_r), .b (dot_mag_r), .p (q_sq)
  );

  vpt_mul #(.A_W(SW), .B_W(SW)) u_len (
    .clk (clk), .a (la4_r), .b (lb4_r), .p (p_len)
  );

  vpt_dly #(.DATA_W(CT_W), .DEPTH(L_M2)) u_dly2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s4_vld_r),
    .data_i (s4_tag_r),
    .vld_o  (m2_vld),
    .data_o (m2_tag)
  );

  // tolerance scaling of the length product
  vpt_mul #(.A_W(TSW), .B_W(QW)) u_tol (
    .clk (clk), .a (tol_sq_r), .b (p_len), .p (rhs)
  );

  vpt_dly #(.DATA_W(D3_W), .DEPTH(L_M3)) u_dly3 (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (m2_vld),
    .data_i ({m2_tag, q_sq}),
    .vld_o  (m3_vld),
    .data_o (m3_data)
  );

  assign m3_tag = m3_data[D3_W-1:QW];
  assign m3_q   = m3_data[QW-1:0];
  assign lhs    = RW'(m3_q) << LHS_SHIFT;

  always_comb begin
    priority if (m3_tag.zero_len) begin
      rel_c = REL_NONE;
    end else if (lhs < rhs) begin
      rel_c = REL_NONE;
    end else if (m3_tag.dot_neg) begin
      rel_c = REL_OPPOSITE;
    end else begin
      rel_c = REL_SAME;
    end
  end

  // output FIFO and credit count
  assign wr_en      = m3_vld;
  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    unique case ({in_accept, out_accept})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
    unique case ({wr_en, out_accept})
      2'b10:   fcnt_nxt = fcnt_r + 1'b1;
      2'b01:   fcnt_nxt = fcnt_r - 1'b1;
      default: fcnt_nxt = fcnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (out_accept) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      fcnt_r <= fcnt_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_mem[wr_ptr_r] <= rel_c;
    end
  end

  a_fifo_no_overflow: assert property (
    @(posedge clk) disable iff (!rst_n) wr_en |-> (fcnt_r != CNT_W'(DEPTH))
  ) else $error("result written into full FIFO");

  a_level_within_credit: assert property (
    @(posedge clk) disable iff (!rst_n) fcnt_r <= cnt_r
  ) else $error("FIFO level exceeds outstanding words");

  a_idle_when_no_credit: assert property (
    @(posedge clk) disable iff (!rst_n) (cnt_r == '0) |-> (!wr_en && !s1_vld_r)
  ) else $error("word in flight with no outstanding credit");

endmodule

`default_nettype wire

[sv/vpt_mul.sv]
// Pipelined unsigned multiplier built from limb partial products.
`default_nettype none

module vpt_mul
  import vpt_pkg::*;
#(
  parameter int A_W = LIMB_W,
  parameter int B_W = LIMB_W
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  localparam int KA    = (A_W + LIMB_W - 1) / LIMB_W;
  localparam int KB    = (B_W + LIMB_W - 1) / LIMB_W;
  localparam int AE_W  = LIMB_W * KA;
  localparam int BE_W  = LIMB_W * KB;
  localparam int PP_W  = 2 * LIMB_W;
  localparam int ROW_W = LIMB_W * (KB + 1);
  localparam int ACC_W = LIMB_W * (KA + KB);

  logic [AE_W-1:0]  a_ext;
  logic [BE_W-1:0]  b_ext;
  logic [PP_W-1:0]  pp_r [KA][KB];
  logic [ROW_W-1:0] even_c [KA];
  logic [ROW_W-1:0] odd_c [KA];
  logic [ROW_W-1:0] row_nxt [KA];
  logic [ROW_W-1:0] row_r [KA][KA];
  logic [ACC_W-1:0] acc_r [KA];

  assign a_ext = AE_W'(a);
  assign b_ext = BE_W'(b);

  always_ff @(posedge clk) begin
    for (int i = 0; i < KA; i++) begin
      for (int j = 0; j < KB; j++) begin
        pp_r[i][j] <= PP_W'(a_ext[i*LIMB_W +: LIMB_W]) * PP_W'(b_ext[j*LIMB_W +: LIMB_W]);
      end
    end
  end

  // even and odd limb products do not overlap, so each row is one add
  always_comb begin
    for (int i = 0; i < KA; i++) begin
      even_c[i] = '0;
      odd_c[i]  = '0;
      for (int j = 0; j < KB; j++) begin
        if (j[0] == 1'b0) begin
          even_c[i][j*LIMB_W +: PP_W] = pp_r[i][j];
        end else begin
          odd_c[i][j*LIMB_W +: PP_W] = pp_r[i][j];
        end
      end
      row_nxt[i] = even_c[i] + odd_c[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < KA; i++) begin
      row_r[0][i] <= row_nxt[i];
    end
    acc_r[0] <= ACC_W'(row_nxt[0]);
  end

  for (genvar s = 1; s < KA; s++) begin : g_acc
    always_ff @(posedge clk) begin
      for (int i = 0; i < KA; i++) begin
        row_r[s][i] <= row_r[s-1][i];
      end
      acc_r[s] <= acc_r[s-1] + (ACC_W'(row_r[s-1][s]) << (LIMB_W * s));
    end
  end

  assign p = acc_r[KA-1][A_W+B_W-1:0];

endmodule

`default_nettype wire

[sv/vpt_dly.sv]
// Delay line for a valid bit and its side data.
`default_nettype none

module vpt_dly #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              vld_o,
  output logic [DATA_W-1:0] data_o
);

  logic              vld_r  [DEPTH];
  logic [DATA_W-1:0] data_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= vld_i;
      for (int k = 1; k < DEPTH; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r[0] <= data_i;
    for (int k = 1; k < DEPTH; k++) begin
      data_r[k] <= data_r[k-1];
    end
  end

  assign vld_o  = vld_r[DEPTH-1];
  assign data_o = data_r[DEPTH-1];

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Testbench for vector_parallel_test_core: directed table plus random vector pairs.
`timescale 1ns / 1ps

module tb_top
  import vpt_pkg::*;
;

  localparam int CW = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 30;
  localparam int PHASE_PAIRS = 130;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [TOL_W-1:0] tol_t;

  typedef struct packed {
    coord_t fx, fy, fz, sx, sy, sz;
  } pair_t;

  typedef struct packed {
    tol_t      tol;
    pair_t     p;
    logic      known;
    relation_t rel;
  } pair_case_t;

  localparam coord_t CMAX = 32'sh7FFF_FFFF;
  localparam coord_t CMIN = 32'sh8000_0000;
  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t NONE = -32'sh0001_0000;
  localparam tol_t   TOL_ONE  = 17'd65536;
  localparam tol_t   TOL_OVER = 17'd65537;
  localparam tol_t   TOL_TOP  = 17'h1FFFF;
  localparam tol_t   TOL_HALF = 17'd32768;
  localparam tol_t   TOL_ZERO = 17'd0;
  localparam int     DIR_ROWS = 24;

  pair_case_t dir_table [0:DIR_ROWS-1] = '{
    '{TOL_RESET, '{0, 0, 0, ONE, 0, 0}, 1'b1, REL_NONE},
    '{TOL_RESET, '{ONE, 2 * ONE, 3, 0, 0, 0}, 1'b1, REL_NONE},
    '{TOL_RESET, '{0, 0, 0, 0, 0, 0}, 1'b1, REL_NONE},
    '{TOL_RESET, '{ONE, 0, 0, ONE, 0, 0}, 1'b1, REL_SAME},
    '{TOL_RESET, '{ONE, 0, 0, NONE, 0, 0}, 1'b1, REL_OPPOSITE},
    '{TOL_RESET, '{ONE, 0, 0, 0, ONE, 0}, 1'b1, REL_NONE},
    '{TOL_RESET, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, REL_SAME},
    '{TOL_RESET, '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1, REL_SAME},
    '{TOL_RESET, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, 1'b1, REL_OPPOSITE},
    '{TOL_RESET, '{CMIN, 0, 0, 0, 0, CMIN}, 1'b1, REL_NONE},
    '{TOL_RESET, '{ONE, ONE, 0, ONE, ONE + 1, 0}, 1'b0, REL_NONE},
    '{TOL_RESET, '{3, 4, 0, -6, -8, 1}, 1'b0, REL_NONE},
    '{TOL_RESET, '{-1, -1, -1, 1, 1, 1}, 1'b1, REL_OPPOSITE},
    '{TOL_RESET, '{CMIN, CMAX, -1, CMAX, CMIN, 1}, 1'b0, REL_NONE},
    '{TOL_ZERO, '{ONE, 0, 0, 0, ONE, 0}, 1'b1, REL_SAME},
    '{TOL_ZERO, '{ONE, 2, 0, -2, ONE, 0}, 1'b1, REL_SAME},
    '{TOL_ZERO, '{ONE, 0, 0, NONE, 1, 0}, 1'b1, REL_OPPOSITE},
    '{TOL_ZERO, '{0, 0, 0, CMIN, CMAX, 1}, 1'b1, REL_NONE},
    '{TOL_ONE, '{ONE, 0, 0, 2 * ONE, 0, 0}, 1'b1, REL_SAME},
    '{TOL_ONE, '{CMIN, 0, 0, CMAX, 0, 0}, 1'b1, REL_OPPOSITE},
    '{TOL_ONE, '{ONE, 1, 0, ONE, 0, 0}, 1'b1, REL_NONE},
    '{TOL_TOP, '{ONE, 0, 0, ONE, 0, 0}, 1'b1, REL_NONE},
    '{TOL_OVER, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, REL_NONE},
    '{TOL_HALF, '{3, 4, 0, 1, 0, 0}, 1'b0, REL_NONE}
  };

  logic clk;
  logic rst_n;

  vpt_in_if #(.COORD_WIDTH(CW)) in_ch ();
  vpt_out_if out_ch ();
  vpt_cfg_if cfg_ch ();

  vector_parallel_test_core #(.COORD_WIDTH(CW)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  relation_t pending_relations [$];
  tol_t      tol_shadow = TOL_RESET;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        calm_left = 0;

  function automatic relation_t predict_relation(pair_t p, tol_t tol);
    logic signed [67:0] a [3];
    logic signed [67:0] b [3];
    logic signed [67:0] dot;
    logic [67:0]        len_a;
    logic [67:0]        len_b;
    logic [255:0]       mag;
    logic [255:0]       lhs;
    logic [255:0]       rhs;
    a[0] = p.fx; a[1] = p.fy; a[2] = p.fz;
    b[0] = p.sx; b[1] = p.sy; b[2] = p.sz;
    dot = 0;
    len_a = 0;
    len_b = 0;
    for (int k = 0; k < 3; k++) begin
      dot   = dot + a[k] * b[k];
      len_a = len_a + a[k] * a[k];
      len_b = len_b + b[k] * b[k];
    end
    if (len_a == 0 || len_b == 0) return REL_NONE;
    if (dot < 0) mag = -dot;
    else mag = dot;
    lhs = (mag * mag) << 32;
    rhs = tol;
    rhs = rhs * tol * len_a * len_b;
    if (lhs >= rhs) return (dot < 0) ? REL_OPPOSITE : REL_SAME;
    return REL_NONE;
  endfunction

  function automatic coord_t rand_coord(int bits);
    logic [31:0] v;
    v = $urandom & ((bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1));
    if ($urandom_range(0, 1)) v = -v;
    return coord_t'(v);
  endfunction

  function automatic coord_t rand_extreme();
    case ($urandom_range(0, 5))
      0: return CMIN;
      1: return CMAX;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return rand_coord(31);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    s;
    int    m;
    int    n;
    int    r;
    r = $urandom_range(0, 19);
    if (r < 3) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (r < 5) begin
      p.fx = $urandom; p.fy = $urandom; p.fz = $urandom;
      if ($urandom_range(0, 1)) begin
        p.sx = p.fx; p.sy = p.fy; p.sz = p.fz;
      end else begin
        p.sx = -p.fx; p.sy = -p.fy; p.sz = -p.fz;
      end
    end else if (r < 13) begin
      // nearly collinear pairs around the tolerance boundary
      s = $urandom_range(2, 27);
      m = $urandom_range(1, 7);
      if ($urandom_range(0, 1)) m = -m;
      n = $urandom_range(0, 8);
      p.fx = rand_coord(s); p.fy = rand_coord(s); p.fz = rand_coord(s);
      p.sx = p.fx * m + rand_coord(n);
      p.sy = p.fy * m + rand_coord(n);
      p.sz = p.fz * m + rand_coord(n);
    end else if (r < 15) begin
      p = {rand_extreme(), rand_extreme(), rand_extreme(),
           rand_extreme(), rand_extreme(), rand_extreme()};
    end else if (r < 16) begin
      p = {rand_coord(31), rand_coord(31), rand_coord(31),
           rand_coord(31), rand_coord(31), rand_coord(31)};
      if ($urandom_range(0, 1)) begin
        p.fx = 0; p.fy = 0; p.fz = 0;
      end else begin
        p.sx = 0; p.sy = 0; p.sz = 0;
      end
    end else if (r < 18) begin
      // perpendicular pairs
      s = $urandom_range(1, 28);
      p.fx = rand_coord(s); p.fy = rand_coord(s); p.fz = 0;
      p.sx = -p.fy; p.sy = p.fx; p.sz = rand_coord($urandom_range(0, 4));
    end else begin
      p = {rand_coord($urandom_range(0, 31)), rand_coord($urandom_range(0, 31)),
           rand_coord($urandom_range(0, 31)), rand_coord($urandom_range(0, 31)),
           rand_coord($urandom_range(0, 31)), rand_coord($urandom_range(0, 31))};
    end
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) calm_left = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_pair(pair_t p, logic known, relation_t rel);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.first_x  <= p.fx;
    in_ch.first_y  <= p.fy;
    in_ch.first_z  <= p.fz;
    in_ch.second_x <= p.sx;
    in_ch.second_y <= p.sy;
    in_ch.second_z <= p.sz;
    do @(posedge clk); while (!in_ch.ready);
    pending_relations.push_back(known ? rel : predict_relation(p, tol_shadow));
  endtask

  task automatic drain_pairs();
    in_ch.valid <= 1'b0;
    while (pending_relations.size() != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(tol_t v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tol_shadow = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    tol_t phase_tols [10];
    phase_tols = '{TOL_RESET, TOL_ZERO, 17'd1, TOL_HALF, 17'd65535, TOL_ONE,
                   TOL_OVER, TOL_TOP, tol_t'($urandom_range(0, 65536)),
                   tol_t'($urandom_range(60000, 65536))};
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.first_x  <= '0;
    in_ch.first_y  <= '0;
    in_ch.first_z  <= '0;
    in_ch.second_x <= '0;
    in_ch.second_y <= '0;
    in_ch.second_z <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].tol != tol_shadow) begin
        drain_pairs();
        write_tolerance(dir_table[i].tol);
      end
      send_pair(dir_table[i].p, dir_table[i].known, dir_table[i].rel);
    end

    foreach (phase_tols[ph]) begin
      drain_pairs();
      write_tolerance(phase_tols[ph]);
      repeat (PHASE_PAIRS) send_pair(rand_pair(), 1'b0, REL_NONE);
    end

    drain_pairs();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int   hold;
    int   r;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(0, 15);
        end else if (r < 50) begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(50, 200);
        end else if (r < 88) begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(10, 40);
        end
      end else begin
        hold--;
      end
    end
  end

  always @(posedge clk) begin
    relation_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_relations.size() == 0) begin
        $display("%0t: relation mismatch expected none actual %0d",
                 $time, out_ch.relation);
        mismatches++;
      end else begin
        want = pending_relations.pop_front();
        if (out_ch.relation !== want) begin
          $display("%0t: relation mismatch expected %0d actual %0d",
                   $time, want, out_ch.relation);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
